### design/itrt_pkg.sv
// Shared types, constants and helper functions for the integer-to-radix text block.
package itrt_pkg;

  // Digit store geometry
  localparam int DIGIT_STORE_DEPTH = 64;
  localparam int ADDR_W            = $clog2(DIGIT_STORE_DEPTH);
  localparam int CNT_W             = ADDR_W + 1;
  localparam int LEN_W             = 7;

  // Radix handling
  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;
  localparam logic [4:0] RADIX_DEC   = 5'd10;

  // Register map, by word index
  localparam logic REG_RADIX = 1'b0;

  // Characters
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // One queued conversion job
  typedef struct packed {
    logic [63:0] mag;
    logic        minus;
  } job_t;

  // Clamp the programmed radix into 2..16
  function automatic logic [4:0] eff_radix(input logic [4:0] r);
    logic [4:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

endpackage

### design/itrt_front.sv
// Front end: accepts items, resolves sign and width, and queues jobs for the back end.
module itrt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        value,
  input  logic               is_signed,
  input  logic               wide_operand,
  input  logic [4:0]         radix,
  output itrt_pkg::job_t     job,
  output logic               job_valid,
  input  logic               job_take
);

  localparam int QDEPTH = 2;

  itrt_pkg::job_t   fifo [QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;
  itrt_pkg::job_t   incoming;
  logic [63:0]      masked;
  logic             sign_bit;
  logic [4:0]       r_eff;

  // Classify the incoming item
  always_comb begin
    r_eff    = itrt_pkg::eff_radix(radix);
    masked   = wide_operand ? value : {32'd0, value[31:0]};
    sign_bit = wide_operand ? value[63] : value[31];
    incoming.minus = is_signed && sign_bit && (r_eff == itrt_pkg::RADIX_DEC);
    if (incoming.minus) begin
      incoming.mag = wide_operand ? (~masked + 64'd1) : {32'd0, ~masked[31:0] + 32'd1};
    end else begin
      incoming.mag = masked;
    end
  end

  assign busy      = (count == 2'(QDEPTH));
  assign push      = start && !busy;
  assign job_valid = (count != 2'd0);
  assign pop       = job_valid && job_take;
  assign job       = fifo[rd_ptr];

  // Store queued jobs
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= incoming;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/itrt_back.sv
// Back end: divides the magnitude into digits a byte per cycle, then emits characters.
module itrt_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [4:0]                 radix,
  input  itrt_pkg::job_t             job,
  input  logic                       job_valid,
  output logic                       job_take,
  output logic                       strobe,
  output logic [7:0]                 character,
  output logic                       last,
  output logic [itrt_pkg::LEN_W-1:0] length
);

  typedef enum logic [1:0] {IDLE, DIVIDE, EMIT} state_t;

  state_t                        state;
  logic [63:0]                   quo;
  logic [3:0]                    rem;
  logic [2:0]                    idx;
  logic [itrt_pkg::CNT_W-1:0]    cnt;
  logic [itrt_pkg::CNT_W-1:0]    ptr;
  logic                          minus;
  logic                          sign_pending;
  logic                          pend;
  logic                          pend_last;

  logic [3:0]                    store [itrt_pkg::DIGIT_STORE_DEPTH];
  logic [3:0]                    rd_data;

  logic [4:0]                    r_eff;
  logic [7:0]                    qbyte;
  logic [3:0]                    rem_next;
  logic [63:0]                   quo_next;
  logic [itrt_pkg::CNT_W-1:0]    cnt_inc;
  logic                          digit_done;
  logic                          wr_en;
  logic                          rd_en;

  // Highest byte of a word that holds a set bit
  function automatic logic [2:0] top_byte(input logic [63:0] w);
    logic [2:0] res;
    res = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (w[i*8 +: 8] != 8'd0) res = 3'(i);
    end
    return res;
  endfunction

  // Divide one byte, carrying the partial remainder through eight restoring steps
  always_comb begin
    logic [4:0] t;
    logic [3:0] r;
    logic [7:0] din;
    r_eff = itrt_pkg::eff_radix(radix);
    din   = quo[idx*8 +: 8];
    r     = rem;
    qbyte = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      t = {r, din[b]};
      if (t >= r_eff) begin
        t        = t - r_eff;
        qbyte[b] = 1'b1;
      end
      r = t[3:0];
    end
    rem_next = r;
    quo_next = quo;
    quo_next[idx*8 +: 8] = qbyte;
  end

  assign cnt_inc    = cnt + 1'b1;
  assign digit_done = (state == DIVIDE) && (idx == 3'd0);
  assign wr_en      = digit_done;
  assign rd_en      = (state == EMIT) && (ptr != '0);
  assign job_take   = (state == IDLE) && job_valid;

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cnt[itrt_pkg::ADDR_W-1:0]] <= rem_next;
    end
    if (rd_en) begin
      rd_data <= store[ptr[itrt_pkg::ADDR_W-1:0] - 1'b1];
    end
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      quo          <= '0;
      cnt          <= '0;
      ptr          <= '0;
      rem          <= '0;
      idx          <= '0;
      minus        <= 1'b0;
      sign_pending <= 1'b0;
      pend         <= 1'b0;
      pend_last    <= 1'b0;
      strobe       <= 1'b0;
      character    <= '0;
      last         <= 1'b0;
      length       <= '0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      length <= '0;
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            quo   <= job.mag;
            minus <= job.minus;
            rem   <= '0;
            idx   <= top_byte(job.mag);
            cnt   <= '0;
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          quo <= quo_next;
          if (idx == 3'd0) begin
            cnt <= cnt_inc;
            if ((quo_next == 64'd0) ||
                (cnt_inc == itrt_pkg::CNT_W'(itrt_pkg::DIGIT_STORE_DEPTH))) begin
              ptr          <= cnt_inc;
              sign_pending <= minus;
              pend         <= 1'b0;
              state        <= EMIT;
            end else begin
              rem <= '0;
              idx <= top_byte(quo_next);
            end
          end else begin
            rem <= rem_next;
            idx <= idx - 3'd1;
          end
        end
        EMIT: begin
          // Issue the next digit read, most significant first
          if (ptr != '0) begin
            ptr       <= ptr - 1'b1;
            pend      <= 1'b1;
            pend_last <= (ptr == itrt_pkg::CNT_W'(1));
          end else begin
            pend <= 1'b0;
          end
          // Drive the sign ahead of the digits, then each digit as it returns
          if (sign_pending) begin
            sign_pending <= 1'b0;
            strobe       <= 1'b1;
            character    <= itrt_pkg::CHAR_MINUS;
          end else if (pend) begin
            strobe    <= 1'b1;
            character <= itrt_pkg::DIGIT_CHARS[rd_data];
            if (pend_last) begin
              last   <= 1'b1;
              length <= itrt_pkg::LEN_W'(cnt) + itrt_pkg::LEN_W'(minus);
              state  <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### design/integer_to_radix_text.sv
// Top level: configuration register, front end and back end of the integer-to-text block.
//
// Converts a 32- or 64-bit integer to ASCII text in base 2..16, most
// significant character first, one character per result.
// Input: raise start with value, is_signed and wide_operand; the item is taken
// at a clock edge where start is high and busy is low. A two-entry job queue
// sits between the front end and the back end, so busy rises only when two
// items are waiting.
// Output: strobe marks each character for exactly one cycle; last and length
// come with the final character. The receiver cannot stall the block.
// Timing: the back end divides one byte of the running quotient per cycle, so
// each digit takes one division step per significant byte of the current quotient
// (1..8); the digits are then read out and emitted, a leading minus going out
// beside the first digit read.
// radix lives at byte address 0 of the APB port (reset 10; 0..1 act as 2,
// 17..31 as 16); write it only while no conversion is in flight.
// Reset clears the queue, the sequencer and sets radix to 10.
module integer_to_radix_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic        is_signed,
  input  logic        wide_operand,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last,
  output logic [6:0]  length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]      radix;
  itrt_pkg::job_t  job;
  logic            job_valid;
  logic            job_take;

  assign pready = 1'b1;

  // Write the radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itrt_pkg::RADIX_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == itrt_pkg::REG_RADIX)) begin
      radix <= pwdata[4:0];
    end
  end

  // Read back the register
  assign prdata = (paddr[2] == itrt_pkg::REG_RADIX) ? {27'd0, radix} : 32'd0;

  itrt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .is_signed    (is_signed),
    .wide_operand (wide_operand),
    .radix        (radix),
    .job          (job),
    .job_valid    (job_valid),
    .job_take     (job_take)
  );

  itrt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .strobe    (strobe),
    .character (character),
    .last      (last),
    .length    (length)
  );

endmodule
